>>> hdl/msfs_pkg.sv
`timescale 1ns / 1ps
package msfs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 16;

    // Motor timeout is 5000 ms less 30 ms for each percent of PWM
    localparam logic [15:0] MOTOR_TIMEOUT_BASE = 16'd5000;
    localparam logic [11:0] MOTOR_TIMEOUT_STEP = 12'd30;

    localparam logic [15:0] RST_MOTOR_CURRENT_LIMIT = 16'd10000;
    localparam logic [11:0] RST_SERVO_LEVEL_LIMIT   = 12'd20;
    localparam logic [15:0] RST_EXIT_HOLD_MS        = 16'd2000;
    localparam logic [15:0] RST_SERVO_WAIT_MS       = 16'd1000;
    localparam logic [15:0] RST_SERVO_AFTER_TRY_MS  = 16'd1000;
    localparam logic [7:0]  RST_SERVO_RETRY_LIMIT   = 8'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MOTOR_CURRENT_LIMIT = 3'd0,
        CFG_SERVO_LEVEL_LIMIT   = 3'd1,
        CFG_EXIT_HOLD_MS        = 3'd2,
        CFG_SERVO_WAIT_MS       = 3'd3,
        CFG_SERVO_AFTER_TRY_MS  = 3'd4,
        CFG_SERVO_RETRY_LIMIT   = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        M_OK    = 3'd0,
        M_WAIT  = 3'd1,
        M_ACCEL = 3'd2,
        M_ERROR = 3'd3,
        M_EXIT  = 3'd4
    } motor_phase_t;

    typedef enum logic [1:0] {
        S_OK    = 2'd0,
        S_WAIT  = 2'd1,
        S_TRY   = 2'd2,
        S_ERROR = 2'd3
    } servo_phase_t;

    typedef enum logic {
        ACT_CHECK = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    typedef struct packed {
        logic [15:0] motor_current_limit;
        logic [11:0] servo_level_limit;
        logic [15:0] exit_hold_ms;
        logic [15:0] servo_wait_ms;
        logic [15:0] servo_after_try_ms;
        logic [7:0]  servo_retry_limit;
    } cfg_t;

    // First field in the highest bits
    typedef struct packed {
        action_t     action;
        logic        servo_blanked;
        logic        servo_check_on;
        logic        motor_check_on;
        logic [7:0]  servo_tries;
        logic [11:0] servo_level;
        logic [6:0]  motor_pwm;
        logic [15:0] motor_current;
        logic [31:0] now_ms;
    } item_t;

    localparam int ITEM_DATA_W = $bits(item_t) - 1;

    typedef struct packed {
        logic         halted;
        logic         servo_error_drive;
        logic         servo_fault_report;
        logic         motor_fault_report;
        logic         servo_timeout_reset_pulse;
        logic         servo_try_pulse;
        logic         motor_normal_pulse;
        logic         motor_try_pulse;
        servo_phase_t servo_phase;
        motor_phase_t motor_phase;
    } result_t;

    typedef struct packed {
        logic         fault_latched;
        logic [31:0]  servo_deadline;
        servo_phase_t servo_phase;
        logic [31:0]  motor_deadline;
        motor_phase_t motor_return_phase;
        motor_phase_t motor_phase;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        fault_latched:      1'b0,
        servo_deadline:     32'd0,
        servo_phase:        S_OK,
        motor_deadline:     32'd0,
        motor_return_phase: M_OK,
        motor_phase:        M_OK
    };

    function automatic logic [15:0] motor_timeout(input logic [6:0] pwm);
        logic [11:0] prod;
        prod = 12'(pwm) * MOTOR_TIMEOUT_STEP;
        return MOTOR_TIMEOUT_BASE - 16'(prod);
    endfunction

    function automatic logic expired(input logic [31:0] deadline, input logic [31:0] now);
        return (deadline != 32'd0) && (deadline < now);
    endfunction

endpackage

>>> hdl/msfs_in_reg.sv
`timescale 1ns / 1ps
module msfs_in_reg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [msfs_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic                              advance,
    output logic                              item_valid,
    output msfs_pkg::item_t                   item
);
    import msfs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Take an item if empty or if the held one moves this cycle
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tvalid || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_t'({s_tuser, s_tdata[ITEM_DATA_W-1:0]});
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hdl/msfs_step.sv
`timescale 1ns / 1ps
module msfs_step (
    input  msfs_pkg::cfg_t    cfg,
    input  msfs_pkg::state_t  state,
    input  msfs_pkg::item_t   item,
    output msfs_pkg::state_t  state_next,
    output msfs_pkg::result_t result
);
    import msfs_pkg::*;

    logic        m_fault;
    logic        m_exp;
    logic        s_fault;
    logic        s_exp;
    logic [31:0] m_timeout_at;
    logic [31:0] exit_at;
    logic [31:0] s_wait_at;
    logic [31:0] s_after_at;
    logic        m_try;
    logic        m_norm;
    logic        m_rep;
    logic        s_try;
    logic        s_tor;
    logic        s_rep;

    assign m_fault      = item.motor_current > cfg.motor_current_limit;
    assign m_exp        = expired(state.motor_deadline, item.now_ms);
    assign s_fault      = (item.servo_level > cfg.servo_level_limit) && !item.servo_blanked;
    assign s_exp        = expired(state.servo_deadline, item.now_ms);
    assign m_timeout_at = item.now_ms + 32'(motor_timeout(item.motor_pwm));
    assign exit_at      = item.now_ms + 32'(cfg.exit_hold_ms);
    assign s_wait_at    = item.now_ms + 32'(cfg.servo_wait_ms);
    assign s_after_at   = item.now_ms + 32'(cfg.servo_after_try_ms);

    always_comb begin
        state_next = state;
        m_try  = 1'b0;
        m_norm = 1'b0;
        m_rep  = 1'b0;
        s_try  = 1'b0;
        s_tor  = 1'b0;
        s_rep  = 1'b0;
        if (item.action == ACT_CLEAR) begin
            state_next = STATE_CLEAR;
        end else if (!state.fault_latched) begin
            if (item.motor_check_on) begin
                unique case (state.motor_phase)
                    M_OK: begin
                        if (m_fault) begin
                            state_next.motor_phase    = M_WAIT;
                            state_next.motor_deadline = m_timeout_at;
                        end else begin
                            state_next.motor_deadline = 32'd0;
                        end
                    end
                    M_WAIT: begin
                        if (m_exp) begin
                            if (m_fault) begin
                                m_try                     = 1'b1;
                                state_next.motor_deadline = m_timeout_at;
                                state_next.motor_phase    = M_ACCEL;
                            end else begin
                                state_next.motor_deadline     = exit_at;
                                state_next.motor_phase        = M_EXIT;
                                state_next.motor_return_phase = M_WAIT;
                            end
                        end
                    end
                    M_ACCEL: begin
                        if (m_exp) begin
                            if (m_fault) begin
                                state_next.motor_phase    = M_ERROR;
                                state_next.motor_deadline = 32'd0;
                            end else begin
                                m_norm                        = 1'b1;
                                state_next.motor_deadline     = exit_at;
                                state_next.motor_phase        = M_EXIT;
                                state_next.motor_return_phase = M_ACCEL;
                            end
                        end
                    end
                    M_ERROR: begin
                        m_rep                    = 1'b1;
                        state_next.fault_latched = 1'b1;
                        if (!m_fault) begin
                            state_next.motor_deadline = 32'd0;
                        end
                    end
                    M_EXIT: begin
                        if (m_exp) begin
                            if (m_fault) begin
                                state_next.motor_deadline = exit_at;
                                state_next.motor_phase    = state.motor_return_phase;
                            end else begin
                                state_next.motor_phase    = M_OK;
                                state_next.motor_deadline = 32'd0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (item.servo_check_on) begin
                unique case (state.servo_phase)
                    S_OK: begin
                        if (s_fault) begin
                            state_next.servo_phase    = S_WAIT;
                            state_next.servo_deadline = s_wait_at;
                        end
                    end
                    S_WAIT: begin
                        if (s_exp) begin
                            if (s_fault) begin
                                if (item.servo_tries > cfg.servo_retry_limit) begin
                                    state_next.servo_phase = S_ERROR;
                                end else begin
                                    s_try                     = 1'b1;
                                    state_next.servo_deadline = s_after_at;
                                    state_next.servo_phase    = S_TRY;
                                end
                            end else begin
                                state_next.servo_deadline = exit_at;
                                state_next.servo_phase    = S_OK;
                            end
                        end
                    end
                    S_TRY: begin
                        if (s_exp) begin
                            state_next.servo_phase    = S_OK;
                            state_next.servo_deadline = 32'd0;
                            s_tor                     = !s_fault;
                        end
                    end
                    S_ERROR: begin
                        s_rep                     = 1'b1;
                        state_next.fault_latched  = 1'b1;
                        state_next.servo_deadline = 32'd0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        result.motor_phase               = state_next.motor_phase;
        result.servo_phase               = state_next.servo_phase;
        result.motor_try_pulse           = m_try;
        result.motor_normal_pulse        = m_norm;
        result.servo_try_pulse           = s_try;
        result.servo_timeout_reset_pulse = s_tor;
        result.motor_fault_report        = m_rep;
        result.servo_fault_report        = s_rep;
        result.servo_error_drive         = m_rep;
        result.halted                    = state_next.fault_latched;
    end

endmodule

>>> hdl/motor_servo_fault_supervisor_core.sv
`timescale 1ns / 1ps
// Motor and servo fault supervisor.
// The slave channel carries one item per periodic check or clear command:
// s_tuser selects the action (0 check, 1 clear), s_tdata holds the time,
// motor and servo measurements and the enable flags. For every item one
// result leaves on the master channel with both supervisor phases, the
// command pulses, the fault reports and the halted flag.
// Limits and hold times are written through cfg_wr_en / cfg_index /
// cfg_wdata while no item is in flight; indexes 6 and 7 are ignored.
// An item waits in the input register and the supervisor step runs between
// that register and the result register, which drives m_tvalid. The
// supervisor state updates in the same cycle as the result register, so one
// item per cycle is sustained while m_tready stays high. When m_tready is low
// with a result pending, the result holds and the input register holds its
// item; s_tready stays high until the input register is occupied as well.
// Reset (aresetn low, synchronous) empties both registers, returns both
// supervisors to ok with no timers running, clears the latch and loads the
// default limits.
module motor_servo_fault_supervisor_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] now_ms, [47:32] motor_current, [54:48] motor_pwm,
    // [66:55] servo_level, [74:67] servo_tries, [75] motor_check_on,
    // [76] servo_check_on, [77] servo_blanked, [79:78] unused
    input  logic [msfs_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] action
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] motor_phase, [4:3] servo_phase, [5] motor_try_pulse,
    // [6] motor_normal_pulse, [7] servo_try_pulse, [8] servo_timeout_reset_pulse,
    // [9] motor_fault_report, [10] servo_fault_report, [11] servo_error_drive,
    // [12] halted, [15:13] zero
    output logic [msfs_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [msfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [msfs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import msfs_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    out_valid_reg;
    logic    item_valid;
    item_t   item;
    logic    advance;

    // Move the held item through when the result register is free
    assign advance = !out_valid_reg || m_tready;

    msfs_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    msfs_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.motor_current_limit <= RST_MOTOR_CURRENT_LIMIT;
            cfg_reg.servo_level_limit   <= RST_SERVO_LEVEL_LIMIT;
            cfg_reg.exit_hold_ms        <= RST_EXIT_HOLD_MS;
            cfg_reg.servo_wait_ms       <= RST_SERVO_WAIT_MS;
            cfg_reg.servo_after_try_ms  <= RST_SERVO_AFTER_TRY_MS;
            cfg_reg.servo_retry_limit   <= RST_SERVO_RETRY_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MOTOR_CURRENT_LIMIT: cfg_reg.motor_current_limit <= cfg_wdata;
                CFG_SERVO_LEVEL_LIMIT:   cfg_reg.servo_level_limit   <= cfg_wdata[11:0];
                CFG_EXIT_HOLD_MS:        cfg_reg.exit_hold_ms        <= cfg_wdata;
                CFG_SERVO_WAIT_MS:       cfg_reg.servo_wait_ms       <= cfg_wdata;
                CFG_SERVO_AFTER_TRY_MS:  cfg_reg.servo_after_try_ms  <= cfg_wdata;
                CFG_SERVO_RETRY_LIMIT:   cfg_reg.servo_retry_limit   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= item_valid;
            if (item_valid) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_valid) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(result_reg);

    // The pending result always reflects the latest supervisor state
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (result_reg.halted == state_reg.fault_latched)
                          && (result_reg.motor_phase == state_reg.motor_phase)
                          && (result_reg.servo_phase == state_reg.servo_phase))
        else $error("result register out of step with supervisor state");

    a_state_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && item_valid) |=> $stable(state_reg))
        else $error("supervisor state changed without a processed item");

    a_motor_report_in_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.motor_fault_report)
            |-> (result_reg.motor_phase == M_ERROR) && result_reg.halted)
        else $error("motor fault reported outside error phase");

    a_servo_report_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.servo_fault_report)
            |-> (result_reg.servo_phase == S_ERROR) && result_reg.halted
                && (state_reg.servo_deadline == 32'd0))
        else $error("servo fault report without a latch");

    a_cfg_no_effect_on_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (!item_valid) |=> $stable(state_reg))
        else $error("supervisor state moved with no item held");

endmodule

>>> tb/sv/tb_motor_servo_fault_supervisor_core.sv
`timescale 1ns / 1ps
module tb_motor_servo_fault_supervisor_core;
    import msfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 280;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    motor_servo_fault_supervisor_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Supervisor copy: limits and state as the block should hold them
    cfg_t lim = '{RST_MOTOR_CURRENT_LIMIT, RST_SERVO_LEVEL_LIMIT, RST_EXIT_HOLD_MS,
                  RST_SERVO_WAIT_MS, RST_SERVO_AFTER_TRY_MS, RST_SERVO_RETRY_LIMIT};
    motor_phase_t m_phase    = M_OK;
    motor_phase_t m_return   = M_OK;
    logic [31:0]  m_deadline = '0;
    servo_phase_t s_phase    = S_OK;
    logic [31:0]  s_deadline = '0;
    logic         latched    = 1'b0;

    item_t   check_queue[$];
    result_t predicted_status[$];
    item_t   on_bus;
    logic    offering      = 1'b0;
    result_t want_next;
    int      src_idle_pct  = 31;
    int      sink_idle_pct = 31;
    int      results_seen  = 0;
    int      mismatches    = 0;
    int      hold_cnt      = 0;
    logic    held_off      = 1'b0;
    int      stall_cycles  = 0;

    task automatic supervise_step(input item_t it, output result_t r);
        logic        m_fault, s_fault, m_due, s_due;
        logic [15:0] m_timeout;
        r = '0;
        if (it.action == ACT_CLEAR) begin
            m_phase    = M_OK;
            m_return   = M_OK;
            m_deadline = '0;
            s_phase    = S_OK;
            s_deadline = '0;
            latched    = 1'b0;
        end else if (!latched) begin
            if (it.motor_check_on) begin
                m_fault   = it.motor_current > lim.motor_current_limit;
                m_due     = (m_deadline != 32'd0) && (m_deadline < it.now_ms);
                m_timeout = 16'd5000 - 16'(it.motor_pwm) * 16'd30;
                case (m_phase)
                    M_OK: begin
                        if (m_fault) begin
                            m_phase    = M_WAIT;
                            m_deadline = it.now_ms + 32'(m_timeout);
                        end else begin
                            m_deadline = '0;
                        end
                    end
                    M_WAIT: begin
                        if (m_due && m_fault) begin
                            r.motor_try_pulse = 1'b1;
                            m_deadline = it.now_ms + 32'(m_timeout);
                            m_phase    = M_ACCEL;
                        end else if (m_due) begin
                            m_deadline = it.now_ms + 32'(lim.exit_hold_ms);
                            m_phase    = M_EXIT;
                            m_return   = M_WAIT;
                        end
                    end
                    M_ACCEL: begin
                        if (m_due && m_fault) begin
                            m_phase    = M_ERROR;
                            m_deadline = '0;
                        end else if (m_due) begin
                            m_deadline = it.now_ms + 32'(lim.exit_hold_ms);
                            r.motor_normal_pulse = 1'b1;
                            m_phase    = M_EXIT;
                            m_return   = M_ACCEL;
                        end
                    end
                    M_ERROR: begin
                        r.motor_fault_report = 1'b1;
                        r.servo_error_drive  = 1'b1;
                        latched = 1'b1;
                        if (!m_fault) m_deadline = '0;
                    end
                    M_EXIT: begin
                        if (m_due && m_fault) begin
                            m_deadline = it.now_ms + 32'(lim.exit_hold_ms);
                            m_phase    = m_return;
                        end else if (m_due) begin
                            m_phase    = M_OK;
                            m_deadline = '0;
                        end
                    end
                    default: ;
                endcase
            end
            // Servo still runs in the step where the motor side latches
            if (it.servo_check_on) begin
                s_fault = (it.servo_level > lim.servo_level_limit) && !it.servo_blanked;
                s_due   = (s_deadline != 32'd0) && (s_deadline < it.now_ms);
                case (s_phase)
                    S_OK: begin
                        if (s_fault) begin
                            s_phase    = S_WAIT;
                            s_deadline = it.now_ms + 32'(lim.servo_wait_ms);
                        end
                    end
                    S_WAIT: begin
                        if (s_due && s_fault) begin
                            if (it.servo_tries > lim.servo_retry_limit) begin
                                s_phase = S_ERROR;
                            end else begin
                                s_deadline = it.now_ms + 32'(lim.servo_after_try_ms);
                                s_phase    = S_TRY;
                                r.servo_try_pulse = 1'b1;
                            end
                        end else if (s_due) begin
                            s_deadline = it.now_ms + 32'(lim.exit_hold_ms);
                            s_phase    = S_OK;
                        end
                    end
                    S_TRY: begin
                        if (s_due) begin
                            s_phase    = S_OK;
                            s_deadline = '0;
                            r.servo_timeout_reset_pulse = !s_fault;
                        end
                    end
                    S_ERROR: begin
                        r.servo_fault_report = 1'b1;
                        latched    = 1'b1;
                        s_deadline = '0;
                    end
                endcase
            end
        end
        r.motor_phase = m_phase;
        r.servo_phase = s_phase;
        r.halted      = latched;
    endtask

    function automatic item_t mk(action_t act, logic [31:0] t, logic [15:0] cur,
                                 logic [6:0] pwm, logic [11:0] lvl, logic [7:0] tries,
                                 logic mon, logic son, logic blk);
        item_t it;
        it.action         = act;
        it.now_ms         = t;
        it.motor_current  = cur;
        it.motor_pwm      = pwm;
        it.servo_level    = lvl;
        it.servo_tries    = tries;
        it.motor_check_on = mon;
        it.servo_check_on = son;
        it.servo_blanked  = blk;
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR result %0d %s: got %0h expected %0h", results_seen, what, got, want);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Driver: offer items from check_queue, predict at acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                supervise_step(on_bus, want_next);
                predicted_status.push_back(want_next);
                offering = 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (check_queue.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                    on_bus   = check_queue.pop_front();
                    offering = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(on_bus[ITEM_DATA_W-1:0]);
                    s_tuser  <= on_bus.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold off once for a long stretch so the input side backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!held_off && results_seen >= 600 && check_queue.size() > 40) begin
            hold_cnt <= 150;
            held_off <= 1'b1;
        end
    end

    // Monitor: compare each status item with the oldest prediction
    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = m_tdata[$bits(result_t)-1:0];
                if (predicted_status.size() == 0) begin
                    report_mismatch("unexpected item", 32'(m_tdata), '0);
                end else begin
                    want = predicted_status.pop_front();
                    check_field("motor_phase", got.motor_phase, want.motor_phase);
                    check_field("servo_phase", got.servo_phase, want.servo_phase);
                    check_field("motor_try_pulse", got.motor_try_pulse, want.motor_try_pulse);
                    check_field("motor_normal_pulse", got.motor_normal_pulse,
                                want.motor_normal_pulse);
                    check_field("servo_try_pulse", got.servo_try_pulse, want.servo_try_pulse);
                    check_field("servo_timeout_reset_pulse", got.servo_timeout_reset_pulse,
                                want.servo_timeout_reset_pulse);
                    check_field("motor_fault_report", got.motor_fault_report,
                                want.motor_fault_report);
                    check_field("servo_fault_report", got.servo_fault_report,
                                want.servo_fault_report);
                    check_field("servo_error_drive", got.servo_error_drive,
                                want.servo_error_drive);
                    check_field("halted", got.halted, want.halted);
                    check_field("padding", m_tdata[M_TDATA_W-1:$bits(result_t)], '0);
                end
            end
            if (hold_cnt != 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("motor_servo_fault_supervisor_core: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic wait_idle();
        while (check_queue.size() != 0 || offering || predicted_status.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(cfg_index_t idx, logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_MOTOR_CURRENT_LIMIT: lim.motor_current_limit = value;
            CFG_SERVO_LEVEL_LIMIT:   lim.servo_level_limit   = value[11:0];
            CFG_EXIT_HOLD_MS:        lim.exit_hold_ms        = value;
            CFG_SERVO_WAIT_MS:       lim.servo_wait_ms       = value;
            CFG_SERVO_AFTER_TRY_MS:  lim.servo_after_try_ms  = value;
            CFG_SERVO_RETRY_LIMIT:   lim.servo_retry_limit   = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_limits(cfg_t c);
        set_reg(CFG_MOTOR_CURRENT_LIMIT, c.motor_current_limit);
        set_reg(CFG_SERVO_LEVEL_LIMIT, 16'(c.servo_level_limit));
        set_reg(CFG_EXIT_HOLD_MS, c.exit_hold_ms);
        set_reg(CFG_SERVO_WAIT_MS, c.servo_wait_ms);
        set_reg(CFG_SERVO_AFTER_TRY_MS, c.servo_after_try_ms);
        set_reg(CFG_SERVO_RETRY_LIMIT, 16'(c.servo_retry_limit));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Episodes of checks on a mostly rising clock, each closed by a clear
    task automatic fill_random(int target);
        item_t        it;
        logic [95:0]  raw;
        logic [31:0]  t;
        int           count, len, mf_pct, sf_pct, step_max;
        count = 0;
        while (count < target) begin
            case ($urandom_range(3, 0))
                0:       t = $urandom_range(1000, 0);
                1:       t = 32'hFFFF_FFFF - $urandom_range(20000, 0);
                default: t = $urandom;
            endcase
            case ($urandom_range(2, 0))
                0:       mf_pct = 0;
                1:       mf_pct = 40;
                default: mf_pct = 90;
            endcase
            case ($urandom_range(2, 0))
                0:       sf_pct = 0;
                1:       sf_pct = 50;
                default: sf_pct = 90;
            endcase
            case ($urandom_range(3, 0))
                0:       step_max = 300;
                1:       step_max = 3000;
                2:       step_max = 12000;
                default: step_max = 80000;
            endcase
            len = $urandom_range(25, 4);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(19, 0) == 0) begin
                    raw       = {$urandom, $urandom, $urandom};
                    it        = raw[$bits(item_t)-1:0];
                    it.action = ($urandom_range(9, 0) == 0) ? ACT_CLEAR : ACT_CHECK;
                end else begin
                    t = t + $urandom_range(step_max, 0);
                    it.action = ACT_CHECK;
                    it.now_ms = t;
                    if ($urandom_range(99, 0) < mf_pct && lim.motor_current_limit != 16'hFFFF)
                        it.motor_current = 16'($urandom_range(65535,
                                                              lim.motor_current_limit + 1));
                    else
                        it.motor_current = 16'($urandom_range(lim.motor_current_limit, 0));
                    if ($urandom_range(99, 0) < sf_pct && lim.servo_level_limit != 12'hFFF)
                        it.servo_level = 12'($urandom_range(4095, lim.servo_level_limit + 1));
                    else
                        it.servo_level = 12'($urandom_range(lim.servo_level_limit, 0));
                    it.motor_pwm = ($urandom_range(4, 0) == 0) ? 7'($urandom_range(127, 0))
                                                              : 7'($urandom_range(100, 0));
                    it.servo_tries = ($urandom_range(9, 0) == 0) ? 8'($urandom)
                                   : 8'($urandom_range(lim.servo_retry_limit + 2, 0));
                    it.motor_check_on = $urandom_range(9, 0) != 0;
                    it.servo_check_on = $urandom_range(9, 0) != 0;
                    it.servo_blanked  = $urandom_range(6, 0) == 0;
                end
                check_queue.push_back(it);
                count++;
            end
            check_queue.push_back(mk(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom));
            count++;
        end
    endtask

    initial begin
        cfg_t c;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Field extremes, wrapped deadline, motor path to error and latch
        check_queue.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        check_queue.push_back(mk(ACT_CHECK, 0, 0, 0, 0, 0, 1, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 7'h7F, 12'hFFF,
                                 8'hFF, 1, 1, 1));
        check_queue.push_back(mk(ACT_CHECK, 100, 16'hFFFF, 100, 0, 0, 1, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 2000, 20000, 0, 0, 0, 1, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 8000, 20000, 0, 0, 0, 1, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 8100, 0, 0, 4095, 0, 1, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 9000, 0, 0, 0, 0, 1, 1, 0));
        check_queue.push_back(mk(ACT_CLEAR, 9100, 0, 0, 0, 0, 1, 1, 0));
        // Servo retry, timeout reset, retry limit exceeded, latch
        check_queue.push_back(mk(ACT_CHECK, 10000, 0, 0, 500, 0, 0, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 12000, 0, 0, 500, 0, 0, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 14000, 0, 0, 0, 0, 0, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 15000, 0, 0, 500, 0, 0, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 17000, 0, 0, 500, 4, 0, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 18000, 0, 0, 500, 4, 0, 1, 0));
        check_queue.push_back(mk(ACT_CLEAR, 19000, 0, 0, 0, 0, 0, 0, 0));
        // Motor exit and return, then accelerate, normal and back to ok
        check_queue.push_back(mk(ACT_CHECK, 20000, 20000, 0, 0, 0, 1, 0, 0));
        check_queue.push_back(mk(ACT_CHECK, 26000, 0, 0, 0, 0, 1, 0, 0));
        check_queue.push_back(mk(ACT_CHECK, 27000, 20000, 0, 0, 0, 1, 0, 0));
        check_queue.push_back(mk(ACT_CHECK, 29000, 20000, 0, 0, 0, 1, 0, 0));
        check_queue.push_back(mk(ACT_CHECK, 32000, 20000, 0, 0, 0, 1, 0, 0));
        check_queue.push_back(mk(ACT_CHECK, 38000, 0, 0, 0, 0, 1, 0, 0));
        check_queue.push_back(mk(ACT_CHECK, 41000, 10000, 0, 0, 0, 1, 0, 0));
        // Servo wait exit with no fault, then both supervisors disabled
        check_queue.push_back(mk(ACT_CHECK, 42000, 0, 0, 100, 0, 0, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 44000, 0, 0, 20, 0, 0, 1, 0));
        check_queue.push_back(mk(ACT_CHECK, 90000, 20000, 0, 500, 0, 0, 0, 0));
        check_queue.push_back(mk(ACT_CLEAR, 91000, 0, 0, 0, 0, 0, 0, 0));
        fill_random(PHASE_ITEMS);
        wait_idle();

        apply_limits('0);
        fill_random(PHASE_ITEMS);
        wait_idle();

        apply_limits('{16'hFFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF});
        fill_random(PHASE_ITEMS);
        wait_idle();

        // Mid-range limits, no idling on either side
        c.motor_current_limit = $urandom_range(40000, 100);
        c.servo_level_limit   = $urandom_range(3000, 10);
        c.exit_hold_ms        = $urandom_range(8000, 0);
        c.servo_wait_ms       = $urandom_range(8000, 0);
        c.servo_after_try_ms  = $urandom_range(8000, 0);
        c.servo_retry_limit   = $urandom_range(10, 0);
        apply_limits(c);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        fill_random(PHASE_ITEMS);
        wait_idle();
        src_idle_pct  = 31;
        sink_idle_pct = 31;

        // Short hold times and tight limits
        c.motor_current_limit = $urandom_range(5000, 0);
        c.servo_level_limit   = $urandom_range(200, 0);
        c.exit_hold_ms        = $urandom_range(500, 0);
        c.servo_wait_ms       = $urandom_range(500, 0);
        c.servo_after_try_ms  = $urandom_range(500, 0);
        c.servo_retry_limit   = $urandom_range(3, 0);
        apply_limits(c);
        fill_random(PHASE_ITEMS);
        wait_idle();

        if (mismatches == 0) begin
            $display("motor_servo_fault_supervisor_core: match");
        end else begin
            $display("motor_servo_fault_supervisor_core: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/msfs_pkg.sv
hdl/msfs_in_reg.sv
hdl/msfs_step.sv
hdl/motor_servo_fault_supervisor_core.sv
tb/sv/tb_motor_servo_fault_supervisor_core.sv
